@@ sv/vau_pkg.sv @@
// shared types, constants and saturation helper for the 3-d vector unit
`default_nettype none

package vau_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int SUMSQ_W     = 64;
    localparam int SQRT_STAGES = SUMSQ_W / 2;
    localparam int WIDE_W      = 72;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 72'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -72'sd2147483648;

    typedef enum logic [3:0] {
        MODE_ADD      = 4'd0,
        MODE_SUB      = 4'd1,
        MODE_SCALE    = 4'd2,
        MODE_CROSS    = 4'd3,
        MODE_DOT      = 4'd4,
        MODE_LENGTH   = 4'd5,
        MODE_UNIT     = 4'd6,
        MODE_SETLEN   = 4'd7,
        MODE_LENGTHEN = 4'd8,
        MODE_SHORTEN  = 4'd9
    } t_mode;

    // per-item context that rides along the sqrt and divide pipelines
    typedef struct packed {
        t_mode                   mode;
        logic [2:0][DATA_W-1:0]  a;
        logic [DATA_W-1:0]       s;
        logic [2:0][DATA_W-1:0]  pre_r;
        logic [DATA_W-1:0]       pre_sc;
        logic                    pre_ovf;
    } t_side;

    // saturate to signed 32 bits, msb of the result is the overflow flag
    function automatic logic [DATA_W:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic [DATA_W:0] res;
        if (v > SAT_MAX) begin
            res = {1'b1, 32'h7fff_ffff};
        end else if (v < SAT_MIN) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[DATA_W-1:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ sv/vau_delay.sv @@
// delay line with travelling valid bits for the item context
`default_nettype none

module vau_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);

    logic [W-1:0]     r_data [DEPTH];
    logic [DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule

`default_nettype wire

@@ sv/vau_front.sv @@
// multiply stage and combine stage: products, squares and non-normalizing results
`default_nettype none

module vau_front #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire vau_pkg::t_mode                      i_mode,
    input  wire logic [2:0][vau_pkg::DATA_W-1:0]     i_a,
    input  wire logic [2:0][vau_pkg::DATA_W-1:0]     i_b,
    input  wire logic [vau_pkg::DATA_W-1:0]          i_s,
    output logic                                     o_valid,
    output vau_pkg::t_side                           o_side,
    output logic [vau_pkg::SUMSQ_W-1:0]              o_sumsq
);

    logic signed [31:0] op_x [6];
    logic signed [31:0] op_y [6];

    // stage 1
    logic                              r_v1;
    vau_pkg::t_mode                    r_mode1;
    logic [2:0][vau_pkg::DATA_W-1:0]   r_a1;
    logic [2:0][vau_pkg::DATA_W-1:0]   r_b1;
    logic [vau_pkg::DATA_W-1:0]        r_s1;
    logic signed [63:0]                r_m  [6];
    logic signed [63:0]                r_sq [3];

    // stage 2
    logic                              r_v2;
    vau_pkg::t_side                    r_side2;
    logic [vau_pkg::SUMSQ_W-1:0]       r_sumsq2;
    vau_pkg::t_side                    n_side2;

    // operand selection per mode
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            op_x[k] = '0;
            op_y[k] = '0;
        end
        case (i_mode)
            vau_pkg::MODE_CROSS: begin
                op_x[0] = i_a[1]; op_y[0] = i_b[2];
                op_x[1] = i_b[1]; op_y[1] = i_a[2];
                op_x[2] = i_b[0]; op_y[2] = i_a[2];
                op_x[3] = i_a[0]; op_y[3] = i_b[2];
                op_x[4] = i_a[0]; op_y[4] = i_b[1];
                op_x[5] = i_b[0]; op_y[5] = i_a[1];
            end
            vau_pkg::MODE_DOT: begin
                for (int k = 0; k < 3; k++) begin
                    op_x[k] = i_a[k];
                    op_y[k] = i_b[k];
                end
            end
            default: begin
                for (int k = 0; k < 3; k++) begin
                    op_x[k] = i_a[k];
                    op_y[k] = i_s;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mode1 <= i_mode;
            r_a1    <= i_a;
            r_b1    <= i_b;
            r_s1    <= i_s;
            for (int k = 0; k < 6; k++) begin
                r_m[k] <= 64'(op_x[k] * op_y[k]);
            end
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= 64'($signed(i_a[k]) * $signed(i_a[k]));
            end
            r_side2  <= n_side2;
            r_sumsq2 <= $unsigned(r_sq[0]) + $unsigned(r_sq[1]) + $unsigned(r_sq[2]);
        end
    end

    // shifted products combined exactly, then saturated
    always_comb begin : combine
        logic signed [63:0]  t [6];
        logic [vau_pkg::DATA_W:0] sr [4];
        for (int k = 0; k < 6; k++) begin
            t[k] = r_m[k] >>> FRAC_BITS;
        end
        for (int k = 0; k < 4; k++) begin
            sr[k] = '0;
        end
        case (r_mode1)
            vau_pkg::MODE_ADD: begin
                for (int k = 0; k < 3; k++) begin
                    sr[k] = vau_pkg::sat32(72'($signed(r_a1[k])) + 72'($signed(r_b1[k])));
                end
            end
            vau_pkg::MODE_SUB: begin
                for (int k = 0; k < 3; k++) begin
                    sr[k] = vau_pkg::sat32(72'($signed(r_a1[k])) - 72'($signed(r_b1[k])));
                end
            end
            vau_pkg::MODE_SCALE: begin
                for (int k = 0; k < 3; k++) begin
                    sr[k] = vau_pkg::sat32(72'(t[k]));
                end
            end
            vau_pkg::MODE_CROSS: begin
                sr[0] = vau_pkg::sat32(72'(t[0]) - 72'(t[1]));
                sr[1] = vau_pkg::sat32(72'(t[2]) - 72'(t[3]));
                sr[2] = vau_pkg::sat32(72'(t[4]) - 72'(t[5]));
            end
            vau_pkg::MODE_DOT: begin
                sr[3] = vau_pkg::sat32(72'(t[0]) + 72'(t[1]) + 72'(t[2]));
            end
            default: begin
            end
        endcase
        n_side2.mode    = r_mode1;
        n_side2.a       = r_a1;
        n_side2.s       = r_s1;
        n_side2.pre_r   = {sr[2][31:0], sr[1][31:0], sr[0][31:0]};
        n_side2.pre_sc  = sr[3][31:0];
        n_side2.pre_ovf = sr[0][32] | sr[1][32] | sr[2][32] | sr[3][32];
    end

    assign o_valid = r_v2;
    assign o_side  = r_side2;
    assign o_sumsq = r_sumsq2;

endmodule

`default_nettype wire

@@ sv/vau_sqrt.sv @@
// pipelined integer square root, one result bit per stage
`default_nettype none

module vau_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [vau_pkg::SUMSQ_W-1:0]   i_n,
    output logic [vau_pkg::DATA_W-1:0]         o_root
);

    localparam int NS = vau_pkg::SQRT_STAGES;

    logic [34:0]                    r_rem  [NS];
    logic [31:0]                    r_root [NS];
    logic [vau_pkg::SUMSQ_W-1:0]    r_n    [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [34:0]                 n_rem;
        logic [31:0]                 n_root;
        logic [vau_pkg::SUMSQ_W-1:0] n_n;

        always_comb begin : step
            logic [34:0]                 rem_in;
            logic [31:0]                 root_in;
            logic [vau_pkg::SUMSQ_W-1:0] num_in;
            logic [34:0]                 sh;
            logic [34:0]                 trial;
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                num_in  = i_n;
            end else begin
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
                num_in  = r_n[k-1];
            end
            sh    = {rem_in[32:0], num_in[63:62]};
            trial = {1'b0, root_in, 2'b01};
            if (sh >= trial) begin
                n_rem  = sh - trial;
                n_root = {root_in[30:0], 1'b1};
            end else begin
                n_rem  = sh;
                n_root = {root_in[30:0], 1'b0};
            end
            n_n = {num_in[61:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_n[k]    <= n_n;
            end
        end
    end

    assign o_root = r_root[NS-1];

endmodule

`default_nettype wire

@@ sv/vau_div.sv @@
// pipelined restoring divider lane: (a << frac) / len, truncating toward zero
`default_nettype none

module vau_div #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [vau_pkg::DATA_W-1:0]    i_num,
    input  wire logic [vau_pkg::DATA_W-1:0]    i_den,
    output logic signed [FRAC_BITS+1:0]        o_quo
);

    localparam int NS = FRAC_BITS + 1;

    logic [31:0]   r_rem [NS];
    logic [NS-1:0] r_q   [NS];
    logic [31:0]   r_den [NS];
    logic          r_neg [NS];

    logic [31:0] mag;
    assign mag = i_num[31] ? (32'd0 - i_num) : i_num;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [31:0]   n_rem;
        logic [NS-1:0] n_q;

        always_comb begin : step
            logic [31:0]   rem_in;
            logic [31:0]   den_in;
            logic [NS-1:0] q_in;
            logic          nbit;
            logic [32:0]   sh;
            if (k == 0) begin
                rem_in = {1'b0, mag[31:1]};
                den_in = i_den;
                q_in   = '0;
                nbit   = mag[0];
            end else begin
                rem_in = r_rem[k-1];
                den_in = r_den[k-1];
                q_in   = r_q[k-1];
                nbit   = 1'b0;
            end
            sh = {rem_in, nbit};
            if (sh >= {1'b0, den_in}) begin
                n_rem = 32'(sh - {1'b0, den_in});
                n_q   = {q_in[NS-2:0], 1'b1};
            end else begin
                n_rem = sh[31:0];
                n_q   = {q_in[NS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
                if (k == 0) begin
                    r_den[k] <= i_den;
                    r_neg[k] <= i_num[31];
                end else begin
                    r_den[k] <= r_den[k-1];
                    r_neg[k] <= r_neg[k-1];
                end
            end
        end
    end

    assign o_quo = r_neg[NS-1] ? -$signed({1'b0, r_q[NS-1]}) : $signed({1'b0, r_q[NS-1]});

endmodule

`default_nettype wire

@@ sv/vector3_arithmetic_unit.sv @@
// top level of the 3-d vector arithmetic unit: pipeline assembly, final select, output skid
//
//  channel  | dir | handshake                          | payload
//  ---------+-----+------------------------------------+------------------------------------
//  s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready  | mode, a_x..a_z, b_x..b_z, scale
//  m_axis   | out | o_m_axis_tvalid / i_m_axis_tready  | r_x, r_y, r_z, r_scalar, flags
//
// one transaction in per cycle while the output skid register is empty, one out per cycle
// while the receiver is ready. stages: two multiply/combine, 32 square root (one root bit
// each), FRAC_BITS + 1 divider (one quotient bit each, Q16.16 by default), one scale
// multiply and the output register. the whole pipeline advances together whenever the
// output skid register is empty, so one more transaction is taken while a result waits.
// synchronous active-low reset clears only valid bits; payload registers are not reset
`default_nettype none

module vector3_arithmetic_unit #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // mode[3:0], a_x[35:4], a_y[67:36], a_z[99:68], b_x[131:100], b_y[163:132],
    // b_z[195:164], scale[227:196], zero pad[231:228]
    input  wire logic [231:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // r_x[31:0], r_y[63:32], r_z[95:64], r_scalar[127:96], zero_length[128],
    // overflow[129], zero pad[135:130]
    output logic [135:0]      o_m_axis_tdata
);

    localparam int DIV_STAGES = FRAC_BITS + 1;
    localparam int EW         = FRAC_BITS + 2;
    localparam int PW         = EW + vau_pkg::DATA_W;
    localparam int SIDE_W     = $bits(vau_pkg::t_side);
    localparam int DW         = vau_pkg::DATA_W;

    // global advance: pipeline moves while the skid slot is free
    logic en;

    logic [2:0][DW-1:0] in_a;
    logic [2:0][DW-1:0] in_b;

    assign in_a = i_s_axis_tdata[99:4];
    assign in_b = i_s_axis_tdata[195:100];

    // front: products and non-normalizing results
    logic                    f_valid;
    vau_pkg::t_side          f_side;
    logic [vau_pkg::SUMSQ_W-1:0] f_sumsq;

    vau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_mode  (vau_pkg::t_mode'(i_s_axis_tdata[3:0])),
        .i_a     (in_a),
        .i_b     (in_b),
        .i_s     (i_s_axis_tdata[227:196]),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_sumsq (f_sumsq)
    );

    // length via square root, context waits alongside
    logic [DW-1:0]  len;
    logic           q_valid;
    logic [SIDE_W-1:0] q_side_bits;

    vau_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_n    (f_sumsq),
        .o_root (len)
    );

    vau_delay #(.W(SIDE_W), .DEPTH(vau_pkg::SQRT_STAGES)) u_dly_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_data  (f_side),
        .o_valid (q_valid),
        .o_data  (q_side_bits)
    );

    vau_pkg::t_side q_side;
    assign q_side = vau_pkg::t_side'(q_side_bits);

    // unit vector components, one divider lane per axis
    logic signed [EW-1:0] quo [3];
    logic                 d_valid;
    logic [SIDE_W+DW-1:0] d_bits;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        vau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (q_side.a[i]),
            .i_den (len),
            .o_quo (quo[i])
        );
    end

    vau_delay #(.W(SIDE_W + DW), .DEPTH(DIV_STAGES)) u_dly_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_data  ({q_side_bits, len}),
        .o_valid (d_valid),
        .o_data  (d_bits)
    );

    vau_pkg::t_side d_side;
    logic [DW-1:0]  d_len;
    assign d_side = vau_pkg::t_side'(d_bits[SIDE_W+DW-1:DW]);
    assign d_len  = d_bits[DW-1:0];

    // scale multiply stage: e * s, zero-length a forces a zero unit vector
    logic                 r_vm;
    vau_pkg::t_side       r_sidem;
    logic [DW-1:0]        r_lenm;
    logic signed [EW-1:0] r_e [3];
    logic signed [PW-1:0] r_p [3];
    logic signed [EW-1:0] e_sel [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e_sel[i] = (d_len == '0) ? '0 : quo[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sidem <= d_side;
            r_lenm  <= d_len;
            for (int i = 0; i < 3; i++) begin
                r_e[i] <= e_sel[i];
                r_p[i] <= PW'(e_sel[i] * $signed(d_side.s));
            end
        end
    end

    // final select and saturation
    logic [DW-1:0] fin_r [3];
    logic [DW-1:0] fin_sc;
    logic          fin_zl;
    logic          fin_ovf;

    always_comb begin : final_sel
        logic signed [PW-1:0] t [3];
        logic [DW:0]          sr [3];
        logic                 norm;
        for (int i = 0; i < 3; i++) begin
            t[i]  = r_p[i] >>> FRAC_BITS;
            sr[i] = '0;
        end
        fin_sc  = '0;
        fin_ovf = 1'b0;
        norm    = 1'b0;
        case (r_sidem.mode)
            vau_pkg::MODE_ADD, vau_pkg::MODE_SUB, vau_pkg::MODE_SCALE,
            vau_pkg::MODE_CROSS, vau_pkg::MODE_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    sr[i] = {1'b0, r_sidem.pre_r[i]};
                end
                fin_sc  = r_sidem.pre_sc;
                fin_ovf = r_sidem.pre_ovf;
            end
            vau_pkg::MODE_LENGTH: begin
                // root can exceed the positive 32-bit range
                fin_sc  = r_lenm[DW-1] ? 32'h7fff_ffff : r_lenm;
                fin_ovf = r_lenm[DW-1];
            end
            vau_pkg::MODE_UNIT: begin
                norm = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    sr[i] = vau_pkg::sat32(72'(r_e[i]));
                end
            end
            vau_pkg::MODE_SETLEN: begin
                norm = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    sr[i] = vau_pkg::sat32(72'(t[i]));
                end
            end
            vau_pkg::MODE_LENGTHEN: begin
                norm = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    sr[i] = vau_pkg::sat32(72'($signed(r_sidem.a[i])) + 72'(t[i]));
                end
            end
            vau_pkg::MODE_SHORTEN: begin
                norm = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    sr[i] = vau_pkg::sat32(72'($signed(r_sidem.a[i])) - 72'(t[i]));
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            fin_r[i] = sr[i][DW-1:0];
        end
        if (norm) begin
            fin_ovf = sr[0][DW] | sr[1][DW] | sr[2][DW];
        end
        fin_zl = norm & (r_lenm == '0);
    end

    logic [135:0] fin_data;
    assign fin_data = {6'd0, fin_ovf, fin_zl, fin_sc, fin_r[2], fin_r[1], fin_r[0]};

    // output register plus one skid slot
    logic         r_out_v;
    logic [135:0] r_out_data;
    logic         r_skid_v;
    logic [135:0] r_skid_data;
    logic         push;
    logic         pop;

    assign en   = ~r_skid_v;
    assign push = en & r_vm;
    assign pop  = r_out_v & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm     <= 1'b0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (en) begin
                r_vm <= d_valid;
            end
            if (!r_skid_v) begin
                if (!r_out_v || pop) begin
                    r_out_v <= push;
                end else if (push) begin
                    r_skid_v <= 1'b1;
                end
            end else if (pop) begin
                r_skid_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            if (!r_out_v || pop) begin
                r_out_data <= fin_data;
            end else begin
                r_skid_data <= fin_data;
            end
        end else if (pop) begin
            r_out_data <= r_skid_data;
        end
    end

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

@@ tb/vector3_arithmetic_unit_tb.sv @@
// testbench for the 3-d vector arithmetic unit: directed and random vectors checked against a predictor
`default_nettype none

// first member sits in the highest bits, so the order follows tdata from the top down
typedef struct packed {
    logic        overflow;
    logic        zero_length;
    logic [31:0] r_scalar;
    logic [31:0] r_z;
    logic [31:0] r_y;
    logic [31:0] r_x;
} t_vec_result;

// holds predicted results in order and counts mismatches
class vector_result_scoreboard;
    t_vec_result pending[$];
    int          mismatches;
    int          unexpected;

    // exact 64-bit integer square root, floor
    static function longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // fixed-point product, arithmetic shift of the full product
    static function logic signed [95:0] fx_mul(logic signed [95:0] x, logic signed [95:0] y);
        logic signed [95:0] p;
        p = x * y;
        return p >>> vau_pkg::FRAC_BITS;
    endfunction

    static function logic [31:0] clamp(logic signed [95:0] v, ref logic ovf);
        if (v > 96'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -96'sd2147483648) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // compute the expected result of one transaction
    function void note_input(logic [3:0] mode, logic signed [31:0] a[3],
                             logic signed [31:0] b[3], logic signed [31:0] s);
        t_vec_result        exp_r;
        logic signed [95:0] av[3], bv[3], ev[3], sv, q;
        logic [31:0]        r[3];
        longint unsigned    sumsq, len;
        logic               ovf;
        ovf   = 1'b0;
        sumsq = 0;
        exp_r = '0;
        sv    = s;
        for (int i = 0; i < 3; i++) begin
            av[i] = a[i];
            bv[i] = b[i];
            ev[i] = 0;
            r[i]  = 0;
            sumsq = sumsq + longint'(av[i] * av[i]);
        end
        len = root_floor(sumsq);
        if (mode >= vau_pkg::MODE_UNIT && mode <= vau_pkg::MODE_SHORTEN) begin
            if (len == 0) exp_r.zero_length = 1'b1;
            else begin
                for (int i = 0; i < 3; i++) begin
                    q     = (av[i] <<< vau_pkg::FRAC_BITS) / $signed({32'd0, len});
                    ev[i] = q;
                end
            end
        end
        case (mode)
            vau_pkg::MODE_ADD:
                for (int i = 0; i < 3; i++) r[i] = clamp(av[i] + bv[i], ovf);
            vau_pkg::MODE_SUB:
                for (int i = 0; i < 3; i++) r[i] = clamp(av[i] - bv[i], ovf);
            vau_pkg::MODE_SCALE:
                for (int i = 0; i < 3; i++) r[i] = clamp(fx_mul(av[i], sv), ovf);
            vau_pkg::MODE_CROSS: begin
                r[0] = clamp(fx_mul(av[1], bv[2]) - fx_mul(bv[1], av[2]), ovf);
                r[1] = clamp(fx_mul(bv[0], av[2]) - fx_mul(av[0], bv[2]), ovf);
                r[2] = clamp(fx_mul(av[0], bv[1]) - fx_mul(bv[0], av[1]), ovf);
            end
            vau_pkg::MODE_DOT:
                exp_r.r_scalar = clamp(fx_mul(av[0], bv[0]) + fx_mul(av[1], bv[1])
                                       + fx_mul(av[2], bv[2]), ovf);
            vau_pkg::MODE_LENGTH: begin
                if (len > 64'd2147483647) begin
                    ovf = 1'b1;
                    exp_r.r_scalar = 32'h7fff_ffff;
                end else begin
                    exp_r.r_scalar = len[31:0];
                end
            end
            vau_pkg::MODE_UNIT:
                for (int i = 0; i < 3; i++) r[i] = clamp(ev[i], ovf);
            vau_pkg::MODE_SETLEN:
                for (int i = 0; i < 3; i++) r[i] = clamp(fx_mul(ev[i], sv), ovf);
            vau_pkg::MODE_LENGTHEN:
                for (int i = 0; i < 3; i++) r[i] = clamp(av[i] + fx_mul(ev[i], sv), ovf);
            vau_pkg::MODE_SHORTEN:
                for (int i = 0; i < 3; i++) r[i] = clamp(av[i] - fx_mul(ev[i], sv), ovf);
            default: ;
        endcase
        exp_r.r_x      = r[0];
        exp_r.r_y      = r[1];
        exp_r.r_z      = r[2];
        exp_r.overflow = ovf;
        pending.push_back(exp_r);
    endfunction

    function void check_result(t_vec_result got);
        t_vec_result want;
        if (pending.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        if (got.r_x !== want.r_x || got.r_y !== want.r_y || got.r_z !== want.r_z ||
            got.r_scalar !== want.r_scalar || got.zero_length !== want.zero_length ||
            got.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
                $display("mismatch: exp x=%h y=%h z=%h sc=%h zl=%b ov=%b, got x=%h y=%h z=%h sc=%h zl=%b ov=%b",
                         want.r_x, want.r_y, want.r_z, want.r_scalar, want.zero_length,
                         want.overflow, got.r_x, got.r_y, got.r_z, got.r_scalar,
                         got.zero_length, got.overflow);
        end
    endfunction
endclass

module vector3_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // mode, a_x, a_y, a_z, b_x, b_y, b_z, scale, zero pad (lowest bit up)
    logic [231:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // r_x, r_y, r_z, r_scalar, zero_length, overflow, zero pad (lowest bit up)
    logic [135:0] o_m_axis_tdata;

    vector_result_scoreboard vec_scoreboard = new();
    bit  stim_done = 1'b0;
    bit  hold_off  = 1'b0;   // long receiver stall requested by the stimulus

    vector3_arithmetic_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // gap length: mostly short, now and then long
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // random 32-bit value biased to the interesting corners
    function automatic logic [31:0] pick_word(int small_range);
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'h0001_0000;
            4, 5: return $urandom();
            default: begin
                if (small_range != 0)
                    return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
                return $urandom();
            end
        endcase
    endfunction

    // offer one transaction and wait for it to be taken
    task automatic send_vec(logic [3:0] mode, logic [31:0] ax, logic [31:0] ay,
                            logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                            logic [31:0] bz, logic [31:0] s, bit no_gap = 0);
        logic signed [31:0] a[3], b[3];
        int gap;
        gap = no_gap ? 0 : gap_len();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, s, bz, by, bx, az, ay, ax, mode};
        a = '{ax, ay, az};
        b = '{bx, by, bz};
        do @(posedge i_clk); while (!o_s_axis_tready);
        vec_scoreboard.note_input(mode, a, b, s);
    endtask

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready)
                vec_scoreboard.check_result(o_m_axis_tdata[129:0]);
            if (hold_off) begin
                i_m_axis_tready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
                i_m_axis_tready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    initial begin
        logic [3:0]  mode;
        logic [31:0] w[7];
        int          n_sent;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every mode, extremes, zero-length vector, unused modes
        for (int m = vau_pkg::MODE_ADD; m <= vau_pkg::MODE_SHORTEN; m++) begin
            send_vec(4'(m), 32'h0001_0000, 32'h0002_0000, 32'hfffe_0000,
                     32'h0003_0000, 32'hffff_8000, 32'h0000_4000, 32'h0002_8000);
        end
        send_vec(vau_pkg::MODE_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1,
                 32'hffff_ffff, 32'h0, 32'h0);
        send_vec(vau_pkg::MODE_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1,
                 32'hffff_ffff, 32'h0, 32'h0);
        send_vec(vau_pkg::MODE_SCALE, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0,
                 32'h0, 32'h0, 32'h8000_0000);
        send_vec(vau_pkg::MODE_CROSS, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
        send_vec(vau_pkg::MODE_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
        send_vec(vau_pkg::MODE_LENGTH, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
                 32'h0, 32'h0, 32'h0);
        for (int m = vau_pkg::MODE_UNIT; m <= vau_pkg::MODE_SHORTEN; m++)
            send_vec(4'(m), 32'h0, 32'h0, 32'h0, 32'h1, 32'h2, 32'h3, 32'h7fff_ffff);
        send_vec(vau_pkg::MODE_SETLEN, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                 32'h7fff_ffff);
        send_vec(4'd10, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 32'h7);
        send_vec(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

        // random part; mid-way the receiver holds off while items keep coming
        n_sent = 0;
        while (n_sent < 900) begin
            if (n_sent == 400) hold_off = 1'b1;
            mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, 9));
            for (int k = 0; k < 7; k++) w[k] = pick_word($urandom_range(0, 1));
            if ($urandom_range(0, 29) == 0) begin
                w[0] = 0;
                w[1] = 0;
                w[2] = 0;
            end
            send_vec(mode, w[0], w[1], w[2], w[3], w[4], w[5], w[6],
                     (n_sent >= 400 && n_sent < 480));
            n_sent++;
        end
        i_s_axis_tvalid <= 1'b0;

        while (vec_scoreboard.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (vec_scoreboard.mismatches == 0 && vec_scoreboard.unexpected == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
sv/vau_pkg.sv
sv/vau_delay.sv
sv/vau_front.sv
sv/vau_sqrt.sv
sv/vau_div.sv
sv/vector3_arithmetic_unit.sv
tb/vector3_arithmetic_unit_tb.sv
